### rtl/prc4_pkg.sv
package prc4_pkg;

   localparam int unsigned KEY_WORD_BITS = 64;
   localparam int unsigned PERM_DEPTH    = 256;
   localparam int unsigned BLOCK_BYTES   = 64;
   localparam int unsigned MSG_WORDS     = 16;
   localparam int unsigned MAX_KEY_BYTES = 16;
   localparam int unsigned SUFFIX_BYTES  = 5;

   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_DATA    = 1'b1;

   typedef enum logic [2:0] {
      CSR_FILE_KEY_LOW  = 3'd0,
      CSR_FILE_KEY_HIGH = 3'd1,
      CSR_KEY_BITS      = 3'd2,
      CSR_OBJECT_NUMBER = 3'd3,
      CSR_GENERATION    = 3'd4
   } csr_index_type;

   localparam logic [31:0] MD5_H0 = 32'h67452301;
   localparam logic [31:0] MD5_H1 = 32'hefcdab89;
   localparam logic [31:0] MD5_H2 = 32'h98badcfe;
   localparam logic [31:0] MD5_H3 = 32'h10325476;

   // per-round additive constant
   function automatic logic [31:0] md5_k(input logic [5:0] r);
      logic [31:0] k;
      unique case (r)
         6'd0:  k = 32'hd76aa478;
         6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;
         6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;
         6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;
         6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;
         6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;
         6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;
         6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;
         6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;
         6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;
         6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;
         6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;
         6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;
         6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;
         6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;
         6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;
         6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;
         6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;
         6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;
         6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;
         6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;
         6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   // rotate amount, indexed by {round group, round low bits}
   function automatic logic [4:0] md5_s(input logic [3:0] idx);
      logic [4:0] s;
      unique case (idx)
         4'd0:  s = 5'd7;
         4'd1:  s = 5'd12;
         4'd2:  s = 5'd17;
         4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;
         4'd5:  s = 5'd9;
         4'd6:  s = 5'd14;
         4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;
         4'd9:  s = 5'd11;
         4'd10: s = 5'd16;
         4'd11: s = 5'd23;
         4'd12: s = 5'd6;
         4'd13: s = 5'd10;
         4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

endpackage

### rtl/pdf_rc4_object_decryptor.sv
// per-object rc4 decryptor for pdf standard security
// config: csr_write/csr_index/csr_data set file key, key length, object
//    number and generation; write only while the block is idle
// request channel (req_valid/req_stall): cmd restart derives the object key
//    (one md5 block over file key bytes + 3 object bytes + 2 generation
//    bytes) and runs the rc4 key schedule; no response for a restart
// request cmd data: one ciphertext byte, xored with the next keystream byte,
//    response on rsp_valid/rsp_plain_byte
// data item: the states dt_i, dt_j, dt_w1 and dt_w2 lie between transfer and
//    rsp_valid when the output is free; restart runs the md5 rounds (md5_a
//    and md5_b per round in one shared round unit), a finish step, the table
//    fill, then the key schedule (ks_rd, ks_j, ks_w1, ks_w2 per entry)
// data bytes: the permutation ram has one read and one write port; a byte
//    makes two reads, two write-backs and a keystream read that overlaps the
//    first write-back; the next byte is taken only back in the idle state
// reset: a pass over every entry loads the identity permutation; req_stall
//    is held high until it ends
// a finished byte sits in the output register while the next request is
//    taken; if rsp_stall holds it there the next byte waits in a holding state
module pdf_rc4_object_decryptor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_plain_byte,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [prc4_pkg::KEY_WORD_BITS-1:0] csr_data
);
   import prc4_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_MD5_A, ST_MD5_B, ST_MD5_F, ST_FILL,
      ST_KS_RD, ST_KS_J, ST_KS_W1, ST_KS_W2,
      ST_DT_I, ST_DT_J, ST_DT_W1, ST_DT_W2, ST_DT_OUT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [63:0] file_key_low_ff, file_key_high_ff;
   logic [7:0]  key_bits_ff;
   logic [23:0] object_number_ff;
   logic [15:0] generation_ff;

   // md5 round unit
   logic [31:0] a_ff, b_ff, c_ff, d_ff, t_ff;
   logic [5:0]  round_ff;
   logic [31:0] msg_ff [MSG_WORDS];
   logic [31:0] key_w_ff [4];
   logic [4:0]  key_len_ff;
   logic [3:0]  kidx_ff;

   // rc4 state
   logic [7:0] cnt_ff, i_ff, j_ff, si_ff, sj_ff, t_addr_ff, pend_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_plain_byte_ff;

   // permutation ram
   logic [7:0] perm_mem [PERM_DEPTH];
   logic [7:0] perm_rd_ff;
   logic       mem_we;
   logic [7:0] mem_waddr, mem_wdata, mem_raddr;

   // message block assembly
   logic [4:0]  nbytes;
   logic [7:0]  blk [BLOCK_BYTES];
   logic [31:0] msg_w [MSG_WORDS];
   logic [4:0]  len_sat;

   always_comb begin
      nbytes  = (key_bits_ff[7:3] > 5'd16) ? 5'd16 : key_bits_ff[7:3];
      len_sat = (nbytes + 5'd5 > 5'd16) ? 5'd16 : nbytes + 5'd5;
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         blk[k] = 8'h00;
         if (k < MAX_KEY_BYTES && 6'(k) < {1'b0, nbytes})
            blk[k] = (k < 8) ? file_key_low_ff[8*(k%8) +: 8] : file_key_high_ff[8*(k%8) +: 8];
         else if (6'(k) == {1'b0, nbytes})
            blk[k] = object_number_ff[7:0];
         else if (6'(k) == {1'b0, nbytes} + 6'd1)
            blk[k] = object_number_ff[15:8];
         else if (6'(k) == {1'b0, nbytes} + 6'd2)
            blk[k] = object_number_ff[23:16];
         else if (6'(k) == {1'b0, nbytes} + 6'd3)
            blk[k] = generation_ff[7:0];
         else if (6'(k) == {1'b0, nbytes} + 6'd4)
            blk[k] = generation_ff[15:8];
         else if (6'(k) == {1'b0, nbytes} + 6'd5)
            blk[k] = 8'h80;
         else if (k == 56)
            blk[k] = {nbytes + 5'd5, 3'b000};
      end
      for (int n = 0; n < MSG_WORDS; n++)
         msg_w[n] = {blk[4*n+3], blk[4*n+2], blk[4*n+1], blk[4*n]};
   end

   // md5 round function
   logic [31:0] f_val, t_val, rot_val;
   logic [3:0]  g_idx;
   logic [4:0]  s_amt;

   always_comb begin
      unique case (round_ff[5:4])
         2'd0: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            g_idx = round_ff[3:0];
         end
         2'd1: begin
            f_val = (d_ff & b_ff) | (~d_ff & c_ff);
            g_idx = 4'(round_ff[3:0] * 4'd5 + 4'd1);
         end
         2'd2: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            g_idx = 4'(round_ff[3:0] * 4'd3 + 4'd5);
         end
         default: begin
            f_val = c_ff ^ (b_ff | ~d_ff);
            g_idx = 4'(round_ff[3:0] * 4'd7);
         end
      endcase
      t_val   = f_val + a_ff + md5_k(round_ff) + msg_ff[g_idx];
      s_amt   = md5_s({round_ff[5:4], round_ff[1:0]});
      rot_val = (t_ff << s_amt) | (t_ff >> (6'd32 - {1'b0, s_amt}));
   end

   // key schedule and keystream arithmetic
   logic [7:0] key_byte, ks_j, dt_j, ks_byte;
   logic       out_free;
   logic       rsp_load;

   always_comb begin
      key_byte = key_w_ff[kidx_ff[3:2]][8*kidx_ff[1:0] +: 8];
      ks_j     = j_ff + perm_rd_ff + key_byte;
      dt_j     = j_ff + perm_rd_ff;
      // the ram read of t saw neither write-back
      if (t_addr_ff == j_ff)
         ks_byte = si_ff;
      else if (t_addr_ff == i_ff)
         ks_byte = sj_ff;
      else
         ks_byte = perm_rd_ff;
      out_free = !rsp_valid_ff || !rsp_stall;
      // a finished byte moves into the output register
      rsp_load = (state_ff == ST_DT_W2 || state_ff == ST_DT_OUT) && out_free;
   end

   // ram port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = cnt_ff;
      mem_raddr = cnt_ff;
      unique case (state_ff)
         ST_INIT, ST_FILL: mem_we = 1'b1;
         ST_KS_J:  mem_raddr = ks_j;
         ST_KS_W1: begin
            mem_we    = 1'b1;
            mem_wdata = perm_rd_ff;
         end
         ST_KS_W2: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = si_ff;
         end
         ST_DT_I:  mem_raddr = i_ff;
         ST_DT_J:  mem_raddr = dt_j;
         ST_DT_W1: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = perm_rd_ff;
            mem_raddr = si_ff + perm_rd_ff;
         end
         ST_DT_W2: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = si_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         perm_mem[mem_waddr] <= mem_wdata;
      perm_rd_ff <= perm_mem[mem_raddr];
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_byte = rsp_plain_byte_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         file_key_low_ff  <= '0;
         file_key_high_ff <= '0;
         key_bits_ff      <= 8'd40;
         object_number_ff <= '0;
         generation_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FILE_KEY_LOW:  file_key_low_ff  <= csr_data;
            CSR_FILE_KEY_HIGH: file_key_high_ff <= csr_data;
            CSR_KEY_BITS:      key_bits_ff      <= csr_data[7:0];
            CSR_OBJECT_NUMBER: object_number_ff <= csr_data[23:0];
            CSR_GENERATION:    generation_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // payload registers of the md5 unit
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_cmd == CMD_RESTART) begin
         for (int n = 0; n < MSG_WORDS; n++)
            msg_ff[n] <= msg_w[n];
      end
      if (state_ff == ST_MD5_A)
         t_ff <= t_val;
      if (state_ff == ST_MD5_F) begin
         key_w_ff[0] <= MD5_H0 + a_ff;
         key_w_ff[1] <= MD5_H1 + b_ff;
         key_w_ff[2] <= MD5_H2 + c_ff;
         key_w_ff[3] <= MD5_H3 + d_ff;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         round_ff     <= '0;
         kidx_ff      <= '0;
         key_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT: begin
               cnt_ff <= cnt_ff + 8'd1;
               if (cnt_ff == 8'hFF)
                  state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_cmd == CMD_RESTART) begin
                     a_ff       <= MD5_H0;
                     b_ff       <= MD5_H1;
                     c_ff       <= MD5_H2;
                     d_ff       <= MD5_H3;
                     round_ff   <= '0;
                     key_len_ff <= len_sat;
                     state_ff   <= ST_MD5_A;
                  end else begin
                     i_ff     <= i_ff + 8'd1;
                     pend_ff  <= req_data_byte;
                     state_ff <= ST_DT_I;
                  end
               end
            end
            ST_MD5_A: state_ff <= ST_MD5_B;
            ST_MD5_B: begin
               a_ff     <= d_ff;
               d_ff     <= c_ff;
               c_ff     <= b_ff;
               b_ff     <= b_ff + rot_val;
               round_ff <= round_ff + 6'd1;
               state_ff <= (round_ff == 6'd63) ? ST_MD5_F : ST_MD5_A;
            end
            ST_MD5_F: begin
               cnt_ff   <= '0;
               state_ff <= ST_FILL;
            end
            ST_FILL: begin
               cnt_ff <= cnt_ff + 8'd1;
               if (cnt_ff == 8'hFF) begin
                  j_ff     <= '0;
                  kidx_ff  <= '0;
                  state_ff <= ST_KS_RD;
               end
            end
            ST_KS_RD: state_ff <= ST_KS_J;
            ST_KS_J: begin
               si_ff    <= perm_rd_ff;
               j_ff     <= ks_j;
               state_ff <= ST_KS_W1;
            end
            ST_KS_W1: state_ff <= ST_KS_W2;
            ST_KS_W2: begin
               cnt_ff  <= cnt_ff + 8'd1;
               kidx_ff <= (kidx_ff == 4'(key_len_ff - 5'd1)) ? 4'd0 : kidx_ff + 4'd1;
               if (cnt_ff == 8'hFF) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_KS_RD;
               end
            end
            ST_DT_I: state_ff <= ST_DT_J;
            ST_DT_J: begin
               si_ff    <= perm_rd_ff;
               j_ff     <= dt_j;
               state_ff <= ST_DT_W1;
            end
            ST_DT_W1: begin
               sj_ff     <= perm_rd_ff;
               t_addr_ff <= si_ff + perm_rd_ff;
               state_ff  <= ST_DT_W2;
            end
            ST_DT_W2: begin
               if (out_free) begin
                  rsp_plain_byte_ff <= pend_ff ^ ks_byte;
                  state_ff          <= ST_IDLE;
               end else begin
                  pend_ff  <= pend_ff ^ ks_byte;
                  state_ff <= ST_DT_OUT;
               end
            end
            ST_DT_OUT: begin
               if (out_free) begin
                  rsp_plain_byte_ff <= pend_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   // a response appears only at the end of a data transfer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DT_W2 || $past(state_ff) == ST_DT_OUT))
      else $error("response without a data item");

   // a restart transfer starts the digest
   a_restart_md5: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == CMD_RESTART) |=> state_ff == ST_MD5_A)
      else $error("restart did not start md5");

   // the ram is never written while waiting for work
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("ram write while idle");

   // key byte index stays inside the object key
   a_kidx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KS_J) |-> ({1'b0, kidx_ff} < key_len_ff))
      else $error("key index out of range");
`endif

endmodule
